// ===== rtl/sle_pkg.sv =====
// Shared constants and types for the sequential list engine.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sle_pkg;

	// list storage
	localparam int DEPTH  = 2048;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 12;
	localparam int POS_W  = 12;
	localparam int WORD_W = 32;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;

	// stream payload widths
	localparam int S_DATA_W = ((POS_W + WORD_W + 7) / 8) * 8;
	localparam int S_USER_W = KIND_W;
	localparam int M_FLD_W  = WORD_W + POS_W + STAT_W + CNT_W;
	localparam int M_DATA_W = ((M_FLD_W + 7) / 8) * 8;

	typedef logic signed [WORD_W-1:0] word_t;

	// request kinds
	localparam logic [KIND_W-1:0] OP_READ   = 3'd0;
	localparam logic [KIND_W-1:0] OP_WRITE  = 3'd1;
	localparam logic [KIND_W-1:0] OP_INSERT = 3'd2;
	localparam logic [KIND_W-1:0] OP_DELETE = 3'd3;
	localparam logic [KIND_W-1:0] OP_LOCATE = 3'd4;
	localparam logic [KIND_W-1:0] OP_PRED   = 3'd5;
	localparam logic [KIND_W-1:0] OP_SUCC   = 3'd6;
	localparam logic [KIND_W-1:0] OP_CLEAR  = 3'd7;

	// result status
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/sle_cell.sv =====
// One storage cell of the list row: a word that takes its neighbor's word on shift.
// Depends on sle_pkg.
`default_nettype none

module sle_cell (
	input  wire                   clk,
	input  wire                   shift,
	input  wire sle_pkg::word_t   din,
	output sle_pkg::word_t        dout
);
	import sle_pkg::*;

	word_t word_q;

	// take the neighbor's word while the row rotates
	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= din;
		end
	end

	assign dout = word_q;

endmodule

`default_nettype wire

// ===== rtl/sle_ctrl.sv =====
// Request sequencer: decodes a transaction, drives one full rotation of the cell row
// if the request walks, rewrites the tail word stream and builds the result. Depends on sle_pkg.
`default_nettype none

module sle_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [sle_pkg::S_DATA_W-1:0]  s_tdata,
	input  wire [sle_pkg::S_USER_W-1:0]  s_tuser,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [sle_pkg::M_DATA_W-1:0] m_tdata,
	input  wire sle_pkg::word_t          head,
	input  wire sle_pkg::word_t          next,
	output logic                         shift,
	output sle_pkg::word_t               feed
);
	import sle_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]          state_q;
	logic                m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic [CNT_W-1:0]    count_q;

	logic [KIND_W-1:0]   kind_q;
	logic [POS_W-1:0]    pos_q;
	word_t               key_q;
	logic [STAT_W-1:0]   st_q;
	word_t               vout_q;
	logic [POS_W-1:0]    pout_q;
	logic                found_q;
	word_t               prev_q;
	logic [IDX_W-1:0]    t_q;

	logic [KIND_W-1:0]   in_kind;
	logic [POS_W-1:0]    in_pos;
	word_t               in_val;
	logic                s_acc;
	logic                ld_out;
	logic                rng_ok;
	logic                ins_ok;
	logic                full;
	logic [STAT_W-1:0]   acc_st;
	logic                acc_walk;
	logic [IDX_W-1:0]    p0;
	logic [CNT_W-1:0]    t_ext;
	logic                is_search;
	logic                match;
	logic [CNT_W-1:0]    cnt_new;

	// request fields
	assign in_kind = s_tuser;
	assign in_pos  = s_tdata[POS_W-1:0];
	assign in_val  = s_tdata[POS_W+WORD_W-1:POS_W];

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign ld_out   = (state_q == ST_FIN) && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// position and capacity checks against the current count
	assign rng_ok = (in_pos != '0) && (in_pos <= count_q);
	assign ins_ok = (in_pos != '0) && (in_pos <= count_q + CNT_W'(1));
	assign full   = (count_q == CNT_W'(DEPTH));

	always_comb begin
		acc_st   = STAT_OK;
		acc_walk = 1'b0;
		unique case (in_kind) inside
			OP_READ, OP_WRITE, OP_DELETE: begin
				if (rng_ok) acc_walk = 1'b1;
				else acc_st = STAT_RANGE;
			end
			OP_INSERT: begin
				if (full) acc_st = STAT_FULL;
				else if (!ins_ok) acc_st = STAT_RANGE;
				else acc_walk = 1'b1;
			end
			OP_LOCATE, OP_PRED, OP_SUCC: begin
				acc_walk = 1'b1;
				acc_st   = STAT_NOTFOUND;
			end
			OP_CLEAR: begin
				acc_st = STAT_OK;
			end
		endcase
	end

	// walk position: t_q is the index of the word now at the row's head
	assign p0        = IDX_W'(pos_q - POS_W'(1));
	assign t_ext     = CNT_W'(t_q);
	assign is_search = (kind_q == OP_LOCATE) || (kind_q == OP_PRED) || (kind_q == OP_SUCC);
	assign match     = is_search && !found_q && (head == key_q) && (t_ext < count_q);
	assign shift     = (state_q == ST_WALK);

	// word written back at the tail
	always_comb begin
		feed = head;
		case (kind_q) inside
			OP_WRITE: begin
				if (t_q == p0) feed = key_q;
			end
			OP_INSERT: begin
				if (t_q == p0) feed = key_q;
				else if (t_q > p0) feed = prev_q;
			end
			OP_DELETE: begin
				if (t_q >= p0) feed = next;
			end
			default: feed = head;
		endcase
	end

	// count after the request
	always_comb begin
		cnt_new = count_q;
		if (st_q == STAT_OK) begin
			case (kind_q) inside
				OP_INSERT: cnt_new = count_q + CNT_W'(1);
				OP_DELETE: cnt_new = count_q - CNT_W'(1);
				OP_CLEAR:  cnt_new = '0;
				default:   cnt_new = count_q;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			count_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) state_q <= acc_walk ? ST_WALK : ST_FIN;
				end
				ST_WALK: begin
					if (t_q == IDX_W'(DEPTH - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (ld_out) begin
						state_q <= ST_IDLE;
						count_q <= cnt_new;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ld_out) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// request and result datapath
	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_q  <= in_kind;
			pos_q   <= in_pos;
			key_q   <= in_val;
			st_q    <= acc_st;
			vout_q  <= '0;
			pout_q  <= '0;
			found_q <= 1'b0;
			t_q     <= '0;
		end else if (state_q == ST_WALK) begin
			t_q    <= t_q + IDX_W'(1);
			prev_q <= head;
			if (match) found_q <= 1'b1;
			case (kind_q) inside
				OP_READ, OP_WRITE, OP_DELETE: begin
					if (t_q == p0) vout_q <= head;
				end
				OP_LOCATE: begin
					if (match) begin
						st_q   <= STAT_OK;
						pout_q <= POS_W'(t_ext + CNT_W'(1));
					end
				end
				OP_PRED: begin
					if (match && (t_q != '0)) begin
						st_q   <= STAT_OK;
						vout_q <= prev_q;
					end
				end
				OP_SUCC: begin
					if (match && (t_ext + CNT_W'(1) < count_q)) begin
						st_q   <= STAT_OK;
						vout_q <= next;
					end
				end
				default: ;
			endcase
		end
		if (ld_out) begin
			m_data_q <= {{(M_DATA_W - M_FLD_W){1'b0}}, cnt_new, st_q, pout_q, vout_q};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sequential_list_engine.sv =====
// Sequential list engine: an ordered list of up to 2048 signed 32-bit words held in a
// row of cells, addressed by 1-based position. Read, overwrite, insert, delete, locate,
// predecessor and successor each rotate the whole row once past the sequencer, one word
// per cycle; a rejected request (bad position, full list) and clear skip the rotation. One
// request is in work at a time; a new request is taken while the previous result still
// waits in the output register. Top level; depends on sle_pkg, sle_cell and sle_ctrl.
`default_nettype none

module sequential_list_engine (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [sle_pkg::S_DATA_W-1:0]  s_tdata,  // position[11:0], value[43:12], zero
	input  wire [sle_pkg::S_USER_W-1:0]  s_tuser,  // kind[2:0]
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [sle_pkg::M_DATA_W-1:0] m_tdata   // value_out[31:0], position_out[43:32],
	                                               // status[45:44], count_out[57:46], zero
);
	import sle_pkg::*;

	word_t word [DEPTH];
	word_t feed;
	logic  shift;

	sle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.head     (word[0]),
		.next     (word[1]),
		.shift    (shift),
		.feed     (feed)
	);

	// cell row: each cell takes its upper neighbor, the last one takes the feed
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_tail
			sle_cell u_cell (.clk(clk), .shift(shift), .din(feed), .dout(word[i]));
		end else begin : g_body
			sle_cell u_cell (.clk(clk), .shift(shift), .din(word[i+1]), .dout(word[i]));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sle_checker.sv =====
// Port-level checks for the sequential list engine, bound to the top level.
// Depends on sle_pkg.
`default_nettype none

module sle_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          s_tvalid,
	input wire                          s_tready,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire [sle_pkg::M_DATA_W-1:0]  m_tdata
);
	import sle_pkg::*;

	logic [POS_W-1:0]  r_pos;
	logic [STAT_W-1:0] r_st;
	logic [CNT_W-1:0]  r_cnt;

	assign r_pos = m_tdata[WORD_W+POS_W-1:WORD_W];
	assign r_st  = m_tdata[WORD_W+POS_W+STAT_W-1:WORD_W+POS_W];
	assign r_cnt = m_tdata[M_FLD_W-1:WORD_W+POS_W+STAT_W];

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	// full status only when the list is at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r_st == STAT_FULL) |-> r_cnt == CNT_W'(DEPTH))
		else $error("full status below capacity");

	// a found position always lies inside the list
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r_pos != '0) |-> (r_st == STAT_OK) && (r_pos <= r_cnt))
		else $error("located position outside the list");

	// count never exceeds capacity
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> r_cnt <= CNT_W'(DEPTH))
		else $error("count beyond capacity");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (.*);

`default_nettype wire

// ===== sim/sle_list_checker.sv =====
// Result checker for the sequential list engine: keeps its own copy of the list,
// predicts one result per accepted request and compares it with the returned one.
// Depends on sle_pkg.

module sle_list_checker
	import sle_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	input  wire                s_tready,
	input  wire [S_DATA_W-1:0] s_tdata,   // position[11:0], value[43:12], zero
	input  wire [S_USER_W-1:0] s_tuser,   // kind[2:0]
	input  wire                m_tvalid,
	input  wire                m_tready,
	input  wire [M_DATA_W-1:0] m_tdata,   // value_out, position_out, status, count_out, zero
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		word_t             value;
		logic [POS_W-1:0]  position;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count;
	} list_result_t;

	// mirrored list contents and length
	word_t        list_words [DEPTH];
	int           list_len = 0;
	list_result_t awaited [$];
	int           fail_count = 0;
	int           waiting = 0;

	assign mismatches  = fail_count;
	assign outstanding = waiting;

	// apply one request to the mirrored list and return what the engine should answer
	function automatic list_result_t apply_request(logic [KIND_W-1:0] kind,
		logic [POS_W-1:0] pos_in, word_t word);
		list_result_t res;
		int p;
		int hit;
		p = int'(pos_in);
		res = '0;
		res.status = STAT_OK;
		// first match, or list_len when the word is absent
		hit = list_len;
		for (int k = list_len - 1; k >= 0; k--)
			if (list_words[k] == word)
				hit = k;
		case (kind)
			OP_READ, OP_WRITE: begin
				if (p < 1 || p > list_len) begin
					res.status = STAT_RANGE;
				end else begin
					res.value = list_words[p-1];
					if (kind == OP_WRITE)
						list_words[p-1] = word;
				end
			end
			OP_INSERT: begin
				// full check takes priority over the position check
				if (list_len >= DEPTH) begin
					res.status = STAT_FULL;
				end else if (p < 1 || p > list_len + 1) begin
					res.status = STAT_RANGE;
				end else begin
					for (int k = list_len; k >= p; k--)
						list_words[k] = list_words[k-1];
					list_words[p-1] = word;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (p < 1 || p > list_len) begin
					res.status = STAT_RANGE;
				end else begin
					res.value = list_words[p-1];
					for (int k = p; k < list_len; k++)
						list_words[k-1] = list_words[k];
					list_len--;
				end
			end
			OP_LOCATE: begin
				if (hit < list_len)
					res.position = POS_W'(hit + 1);
				else
					res.status = STAT_NOTFOUND;
			end
			OP_PRED: begin
				if (hit < list_len && hit > 0)
					res.value = list_words[hit-1];
				else
					res.status = STAT_NOTFOUND;
			end
			OP_SUCC: begin
				if (hit + 1 < list_len)
					res.value = list_words[hit+1];
				else
					res.status = STAT_NOTFOUND;
			end
			default: begin
				list_len = 0;
			end
		endcase
		res.count = CNT_W'(list_len);
		return res;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		list_result_t seen;
		list_result_t want;
		if (arst_n) begin
			// returned transaction against the oldest prediction
			if (m_tvalid && m_tready) begin
				seen.value    = m_tdata[WORD_W-1:0];
				seen.position = m_tdata[WORD_W +: POS_W];
				seen.status   = m_tdata[WORD_W+POS_W +: STAT_W];
				seen.count    = m_tdata[WORD_W+POS_W+STAT_W +: CNT_W];
				if (awaited.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, got value %0d status %0d count %0d",
						$time, seen.value, seen.status, seen.count);
				end else begin
					want = awaited.pop_front();
					check_field("value_out", want.value, seen.value);
					check_field("position_out", want.position, seen.position);
					check_field("status", want.status, seen.status);
					check_field("count_out", want.count, seen.count);
				end
			end
			// predict each accepted request
			if (s_tvalid && s_tready)
				awaited.push_back(apply_request(s_tuser, s_tdata[POS_W-1:0],
					s_tdata[POS_W +: WORD_W]));
			waiting = awaited.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Top of the sequential list engine simulation: clock, reset, request stimulus and
// result back-pressure; the verdict comes from sle_list_checker.
// Depends on sle_pkg, sequential_list_engine and sle_list_checker.

module testbench;
	import sle_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // position[11:0], value[43:12], zero
	logic [S_USER_W-1:0] s_tuser = '0;   // kind[2:0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // value_out, position_out, status, count_out, zero

	int mismatches;
	int outstanding;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_off = 1'b0;

	// rough view of the list, used only to steer stimulus
	int    list_len_est = 0;
	word_t recent_words [$];

	logic [KIND_W-1:0] positional_kinds [4] = '{OP_READ, OP_WRITE, OP_INSERT, OP_DELETE};
	logic [KIND_W-1:0] search_kinds [3]     = '{OP_LOCATE, OP_PRED, OP_SUCC};

	sequential_list_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sle_list_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// long hold-off so the engine backs up and stalls its request side
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (6000) @(posedge clk);
		hold_off = 1'b0;
	end

	// one request transaction, entered and left at a falling edge
	task automatic issue_request(logic [KIND_W-1:0] kind, int pos, word_t word);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= S_DATA_W'({word, pos[POS_W-1:0]});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		// keep the length estimate in step
		case (kind)
			OP_INSERT: if (list_len_est < DEPTH && pos >= 1 && pos <= list_len_est + 1)
				list_len_est++;
			OP_DELETE: if (pos >= 1 && pos <= list_len_est)
				list_len_est--;
			OP_CLEAR:  list_len_est = 0;
			default: ;
		endcase
		if (kind == OP_INSERT || kind == OP_WRITE) begin
			recent_words.push_back(word);
			if (recent_words.size() > 16)
				void'(recent_words.pop_front());
		end
	endtask

	// words that are likely to be in the list, duplicates, extremes or noise
	function automatic word_t pick_word();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35 && recent_words.size() > 0)
			return recent_words[$urandom_range(0, recent_words.size() - 1)];
		if (roll < 60)
			return word_t'($urandom_range(0, 7));
		if (roll < 66)
			return (roll & 1) ? 32'sh7fffffff : 32'sh80000000;
		return word_t'($urandom);
	endfunction

	task automatic random_request();
		int roll;
		int hi;
		logic [KIND_W-1:0] kind;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			// raw noise across all fields
			issue_request(KIND_W'($urandom_range(0, 7)), $urandom_range(0, 4095),
				word_t'($urandom));
		end else if (roll < 14) begin
			// positional request outside the list
			kind = positional_kinds[$urandom_range(0, 3)];
			hi = (kind == OP_INSERT) ? list_len_est + 2 : list_len_est + 1;
			issue_request(kind, $urandom_range(0, 1) ? 0 : $urandom_range(hi, 4095),
				pick_word());
		end else if (roll < 44 || list_len_est < 4) begin
			issue_request(OP_INSERT, $urandom_range(1, list_len_est + 1), pick_word());
		end else if (roll < 56) begin
			issue_request(OP_DELETE, $urandom_range(1, list_len_est), word_t'($urandom));
		end else if (roll < 64) begin
			issue_request(OP_READ, $urandom_range(1, list_len_est), word_t'($urandom));
		end else if (roll < 72) begin
			issue_request(OP_WRITE, $urandom_range(1, list_len_est), pick_word());
		end else if (roll < 98) begin
			issue_request(search_kinds[$urandom_range(0, 2)], $urandom_range(0, 4095),
				pick_word());
		end else begin
			issue_request(OP_CLEAR, $urandom_range(0, 4095), word_t'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list: every access fails
		issue_request(OP_READ, 1, 0);
		issue_request(OP_LOCATE, 0, 0);
		issue_request(OP_PRED, 0, 0);
		issue_request(OP_DELETE, 1, 0);
		issue_request(OP_INSERT, 0, 9);
		issue_request(OP_INSERT, 2, 9);
		// build -1, max, min, 0 with inserts at front and end
		issue_request(OP_INSERT, 1, 32'sh7fffffff);
		issue_request(OP_INSERT, 2, 32'sh80000000);
		issue_request(OP_INSERT, 1, -1);
		issue_request(OP_INSERT, 4, 0);
		issue_request(OP_INSERT, 4095, 3);
		issue_request(OP_READ, 4, 0);
		issue_request(OP_READ, 2048, 0);
		issue_request(OP_WRITE, 2, 5);
		issue_request(OP_WRITE, 0, 6);
		// duplicate 5: searches must take the first match
		issue_request(OP_INSERT, 4, 5);
		issue_request(OP_LOCATE, 0, 5);
		issue_request(OP_PRED, 0, -1);
		issue_request(OP_PRED, 0, 32'sh80000000);
		issue_request(OP_SUCC, 0, 0);
		issue_request(OP_SUCC, 0, 5);
		issue_request(OP_DELETE, 1, 0);
		issue_request(OP_DELETE, 4, 0);
		issue_request(OP_CLEAR, 0, 0);
		issue_request(OP_READ, 1, 0);

		// random traffic under different idle patterns
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_req       = 1'b1;
				end
				1: begin
					send_idle_pct  = 80;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 80;
				end
				default: begin
					send_idle_pct  = 30;
					recv_stall_pct = 30;
				end
			endcase
			repeat (66)
				random_request();
		end
		s_tvalid <= 1'b0;

		// drain, then allow for one more walk in case of stray results
		while (outstanding != 0)
			@(posedge clk);
		repeat (2100) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#12000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sle_pkg.sv
rtl/sle_cell.sv
rtl/sle_ctrl.sv
rtl/sequential_list_engine.sv
rtl/sle_checker.sv
sim/sle_list_checker.sv
sim/testbench.sv
